// ===== hw/rtl/nsc_pkg.sv =====
// Shared types and constants of the NMEA sentence checker.
package nsc_pkg;

  typedef enum logic [1:0] {
    EVT_VALID    = 2'd0,
    EVT_INVALID  = 2'd1,
    EVT_OVERFLOW = 2'd2
  } evt_kind_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_GGA   = 2'd1,
    CLS_RMC   = 2'd2,
    CLS_GST   = 2'd3
  } sent_class_e;

  typedef enum logic [2:0] {
    FIX_NONE        = 3'd0,
    FIX_SINGLE      = 3'd1,
    FIX_DIFF        = 3'd2,
    FIX_CARRIER_INT = 3'd3,
    FIX_CARRIER_FLT = 3'd4
  } fix_kind_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [23:0] TYPE_GGA    = 24'h474741;
  localparam logic [23:0] TYPE_RMC    = 24'h524D43;
  localparam logic [23:0] TYPE_GST    = 24'h475354;
  localparam logic [23:0] TYPE_DASHES = 24'h2D2D2D;

  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    evt_kind_e   kind;
    logic [23:0] ptype;
    logic        many_fields;
    logic [7:0]  quality;
    logic [7:0]  sats;
    logic        lat;
    logic        lon;
  } cmd_t;

endpackage

// ===== hw/rtl/nsc_front.sv =====
// Line tracker: checksum, type and GGA field capture, one byte per cycle.
module nsc_front #(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_vld,
  input  logic [7:0]    rx_byte,
  output logic          cmd_push,
  output nsc_pkg::cmd_t cmd_data
);

  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             dollar_r, dollar_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             star_r, star_nxt;
  logic [1:0]       after_r, after_nxt;
  logic [7:0]       rsum_r, rsum_nxt;
  logic             hexok_r, hexok_nxt;
  logic [23:0]      ptype_r, ptype_nxt;
  logic [4:0]       field_r, field_nxt;
  logic [7:0]       qual_r, qual_nxt;
  logic [7:0]       sats_r, sats_nxt;
  logic             dopen_r, dopen_nxt;
  logic             lat_r, lat_nxt;
  logic             lon_r, lon_nxt;

  logic        is_cr, is_lf, is_digit, room, ok, do_clear;
  logic [4:0]  hex;
  logic [11:0] qual_wide;
  logic [7:0]  digit;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  assign is_cr     = (rx_byte == nsc_pkg::CH_CR);
  assign is_lf     = (rx_byte == nsc_pkg::CH_LF);
  assign is_digit  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign room      = (len_r < LEN_W'(LINE_CAPACITY - 1));
  assign hex       = hex_decode(rx_byte);
  assign digit     = rx_byte - 8'h30;
  assign qual_wide = 12'(qual_r) * 12'd10 + 12'(digit);

  assign ok = dollar_r && star_r && (after_r >= 2'd2) && hexok_r &&
              (rsum_r == xor_r) && (len_r >= LEN_W'(6));

  assign cmd_push = byte_vld && !is_cr && (is_lf ? (len_r != '0) : !room);
  assign do_clear = byte_vld && !is_cr && (is_lf || !room);

  always_comb begin
    cmd_data.kind        = !is_lf ? nsc_pkg::EVT_OVERFLOW :
                           (ok ? nsc_pkg::EVT_VALID : nsc_pkg::EVT_INVALID);
    cmd_data.ptype       = ptype_r;
    cmd_data.many_fields = (field_r >= 5'd9);
    cmd_data.quality     = qual_r;
    cmd_data.sats        = sats_r;
    cmd_data.lat         = lat_r;
    cmd_data.lon         = lon_r;
  end

  always_comb begin
    len_nxt    = len_r;
    dollar_nxt = dollar_r;
    xor_nxt    = xor_r;
    star_nxt   = star_r;
    after_nxt  = after_r;
    rsum_nxt   = rsum_r;
    hexok_nxt  = hexok_r;
    ptype_nxt  = ptype_r;
    field_nxt  = field_r;
    qual_nxt   = qual_r;
    sats_nxt   = sats_r;
    dopen_nxt  = dopen_r;
    lat_nxt    = lat_r;
    lon_nxt    = lon_r;
    if (do_clear) begin
      len_nxt    = '0;
      dollar_nxt = 1'b0;
      xor_nxt    = 8'd0;
      star_nxt   = 1'b0;
      after_nxt  = 2'd0;
      rsum_nxt   = 8'd0;
      hexok_nxt  = 1'b1;
      ptype_nxt  = 24'd0;
      field_nxt  = 5'd0;
      qual_nxt   = 8'd0;
      sats_nxt   = 8'd0;
      dopen_nxt  = 1'b1;
      lat_nxt    = 1'b0;
      lon_nxt    = 1'b0;
    end else if (byte_vld && !is_cr) begin
      if (len_r == '0) dollar_nxt = (rx_byte == nsc_pkg::CH_DOLLAR);
      if (len_r >= LEN_W'(3) && len_r <= LEN_W'(5)) ptype_nxt = {ptype_r[15:0], rx_byte};
      if (!star_r) begin
        if (len_r != '0 && rx_byte == nsc_pkg::CH_STAR) begin
          star_nxt = 1'b1;
        end else begin
          if (len_r != '0) xor_nxt = xor_r ^ rx_byte;
          if (rx_byte == nsc_pkg::CH_COMMA) begin
            if (field_r < 5'd15) begin
              field_nxt = field_r + 5'd1;
              dopen_nxt = 1'b1;
            end else begin
              dopen_nxt = 1'b0;
            end
          end else begin
            if (field_r == 5'd2) lat_nxt = 1'b1;
            if (field_r == 5'd4) lon_nxt = 1'b1;
            if (field_r == 5'd6 && dopen_r && is_digit) begin
              qual_nxt = (qual_wide > 12'd255) ? 8'd255 : qual_wide[7:0];
            end else if (field_r == 5'd7 && dopen_r && is_digit) begin
              sats_nxt = 8'(sats_r * 8'd10 + digit);
            end else begin
              dopen_nxt = 1'b0;
            end
          end
        end
      end else if (after_r < 2'd3) begin
        if (after_r < 2'd2) begin
          if (!hex[4]) hexok_nxt = 1'b0;
          else         rsum_nxt  = {rsum_r[3:0], hex[3:0]};
        end
        after_nxt = after_r + 2'd1;
      end
      len_nxt = len_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      dollar_r <= 1'b0;
      xor_r    <= 8'd0;
      star_r   <= 1'b0;
      after_r  <= 2'd0;
      rsum_r   <= 8'd0;
      hexok_r  <= 1'b1;
      ptype_r  <= 24'd0;
      field_r  <= 5'd0;
      qual_r   <= 8'd0;
      sats_r   <= 8'd0;
      dopen_r  <= 1'b1;
      lat_r    <= 1'b0;
      lon_r    <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      dollar_r <= dollar_nxt;
      xor_r    <= xor_nxt;
      star_r   <= star_nxt;
      after_r  <= after_nxt;
      rsum_r   <= rsum_nxt;
      hexok_r  <= hexok_nxt;
      ptype_r  <= ptype_nxt;
      field_r  <= field_nxt;
      qual_r   <= qual_nxt;
      sats_r   <= sats_nxt;
      dopen_r  <= dopen_nxt;
      lat_r    <= lat_nxt;
      lon_r    <= lon_nxt;
    end
  end

endmodule

// ===== hw/rtl/nsc_cmd_queue.sv =====
// Short queue of line events between the line tracker and the commit stage.
module nsc_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nsc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output nsc_pkg::cmd_t head,
  output logic          head_vld
);

  localparam int unsigned AW = $clog2(nsc_pkg::Q_DEPTH);

  nsc_pkg::cmd_t slot_r [nsc_pkg::Q_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == (AW+1)'(nsc_pkg::Q_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = slot_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + AW'(1);
      if (do_pop)  rptr_r <= rptr_r + AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (AW+1)'(1);
      else if (!do_push && do_pop) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end

endmodule

// ===== hw/rtl/nsc_back.sv =====
// Commit stage: fix state, counters and the result register.
module nsc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_vld,
  input  nsc_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_vld,
  input  logic          res_pop,
  output logic [1:0]    event_kind,
  output logic [1:0]    sentence_class,
  output logic [23:0]   type_letters,
  output logic          gga_applied,
  output logic [2:0]    fix_kind,
  output logic [7:0]    satellite_count,
  output logic          position_fix,
  output logic [15:0]   valid_total,
  output logic [15:0]   invalid_total,
  output logic [15:0]   overflow_total
);

  logic                 res_vld_r;
  nsc_pkg::evt_kind_e   kind_r;
  nsc_pkg::sent_class_e cls_r, cls_nxt;
  logic                 applied_r, applied_nxt;
  logic [23:0]          ltype_r, ltype_nxt;
  logic [2:0]           fix_r, fix_nxt;
  logic [7:0]           sats_r, sats_nxt;
  logic                 flag_r, flag_nxt;
  logic [15:0]          vcnt_r, vcnt_nxt;
  logic [15:0]          icnt_r, icnt_nxt;
  logic [15:0]          ocnt_r, ocnt_nxt;

  function automatic logic [2:0] map_quality(input logic [7:0] q);
    logic [2:0] r;
    unique case (q)
      8'd0:    r = nsc_pkg::FIX_NONE;
      8'd2:    r = nsc_pkg::FIX_DIFF;
      8'd4:    r = nsc_pkg::FIX_CARRIER_INT;
      8'd5:    r = nsc_pkg::FIX_CARRIER_FLT;
      default: r = nsc_pkg::FIX_SINGLE;
    endcase
    return r;
  endfunction

  assign cmd_take = cmd_vld && (!res_vld_r || res_pop);

  always_comb begin
    cls_nxt     = nsc_pkg::CLS_OTHER;
    applied_nxt = 1'b0;
    ltype_nxt   = ltype_r;
    fix_nxt     = fix_r;
    sats_nxt    = sats_r;
    flag_nxt    = flag_r;
    vcnt_nxt    = vcnt_r;
    icnt_nxt    = icnt_r;
    ocnt_nxt    = ocnt_r;
    unique case (cmd.kind)
      nsc_pkg::EVT_VALID: begin
        vcnt_nxt  = vcnt_r + 16'd1;
        ltype_nxt = cmd.ptype;
        priority if (cmd.ptype == nsc_pkg::TYPE_GGA) begin
          cls_nxt = nsc_pkg::CLS_GGA;
          if (cmd.many_fields) begin
            applied_nxt = 1'b1;
            fix_nxt     = map_quality(cmd.quality);
            sats_nxt    = cmd.sats;
            flag_nxt    = (cmd.quality != 8'd0) && cmd.lat && cmd.lon;
          end
        end else if (cmd.ptype == nsc_pkg::TYPE_RMC) begin
          cls_nxt = nsc_pkg::CLS_RMC;
        end else if (cmd.ptype == nsc_pkg::TYPE_GST) begin
          cls_nxt = nsc_pkg::CLS_GST;
        end else begin
          cls_nxt = nsc_pkg::CLS_OTHER;
        end
      end
      nsc_pkg::EVT_INVALID:  icnt_nxt = icnt_r + 16'd1;
      nsc_pkg::EVT_OVERFLOW: ocnt_nxt = ocnt_r + 16'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      ltype_r   <= nsc_pkg::TYPE_DASHES;
      fix_r     <= nsc_pkg::FIX_NONE;
      sats_r    <= 8'd0;
      flag_r    <= 1'b0;
      vcnt_r    <= 16'd0;
      icnt_r    <= 16'd0;
      ocnt_r    <= 16'd0;
    end else if (cmd_take) begin
      res_vld_r <= 1'b1;
      ltype_r   <= ltype_nxt;
      fix_r     <= fix_nxt;
      sats_r    <= sats_nxt;
      flag_r    <= flag_nxt;
      vcnt_r    <= vcnt_nxt;
      icnt_r    <= icnt_nxt;
      ocnt_r    <= ocnt_nxt;
    end else if (res_pop) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      kind_r    <= cmd.kind;
      cls_r     <= cls_nxt;
      applied_r <= applied_nxt;
    end
  end

  assign res_vld         = res_vld_r;
  assign event_kind      = kind_r;
  assign sentence_class  = cls_r;
  assign type_letters    = ltype_r;
  assign gga_applied     = applied_r;
  assign fix_kind        = fix_r;
  assign satellite_count = sats_r;
  assign position_fix    = flag_r;
  assign valid_total     = vcnt_r;
  assign invalid_total   = icnt_r;
  assign overflow_total  = ocnt_r;

endmodule

// ===== hw/rtl/nmea_sentence_checker.sv =====
// NMEA sentence checker: one received byte per cycle in, one line event per cycle out,
// while full is low and results are popped; bytes enter through push/full. The line
// tracker updates checksum, type and GGA field state for each byte taken. A line feed
// that ends a non-empty line, or a byte that would overrun LINE_CAPACITY-1 held bytes,
// posts one event into a two-entry queue; the commit stage drains one event per cycle
// into the result register while it is empty or being popped, so queued results can
// be popped every cycle. full rises only while the queue holds two unread events.
// No clearing pass is needed after reset.
module nmea_sentence_checker #(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_event_kind,
  output logic [1:0]  out_sentence_class,
  output logic [23:0] out_type_letters,
  output logic        out_gga_applied,
  output logic [2:0]  out_fix_kind,
  output logic [7:0]  out_satellite_count,
  output logic        out_position_fix,
  output logic [15:0] out_valid_total,
  output logic [15:0] out_invalid_total,
  output logic [15:0] out_overflow_total
);

  logic          byte_vld, cmd_push, q_full, head_vld, cmd_take, res_vld;
  nsc_pkg::cmd_t cmd_data, head;

  assign full     = q_full;
  assign byte_vld = push && !q_full;
  assign empty    = !res_vld;

  nsc_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .rx_byte  (in_rx_byte),
    .cmd_push (cmd_push),
    .cmd_data (cmd_data)
  );

  nsc_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (q_full),
    .pop       (cmd_take),
    .head      (head),
    .head_vld  (head_vld)
  );

  nsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_vld         (head_vld),
    .cmd             (head),
    .cmd_take        (cmd_take),
    .res_vld         (res_vld),
    .res_pop         (pop),
    .event_kind      (out_event_kind),
    .sentence_class  (out_sentence_class),
    .type_letters    (out_type_letters),
    .gga_applied     (out_gga_applied),
    .fix_kind        (out_fix_kind),
    .satellite_count (out_satellite_count),
    .position_fix    (out_position_fix),
    .valid_total     (out_valid_total),
    .invalid_total   (out_invalid_total),
    .overflow_total  (out_overflow_total)
  );

endmodule

// ===== hw/rtl/nsc_checker.sv =====
// Port-level assertions for the NMEA sentence checker and their bind.
module nsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_event_kind,
  input logic [1:0]  out_sentence_class,
  input logic [23:0] out_type_letters,
  input logic        out_gga_applied,
  input logic [15:0] out_valid_total
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_valid_total) &&
                          $stable(out_event_kind)))
    else $error("waiting result changed before transfer");

  a_non_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_kind != nsc_pkg::EVT_VALID) |->
      (out_sentence_class == nsc_pkg::CLS_OTHER && !out_gga_applied))
    else $error("rejected or dropped line carries a class");

  a_applied_gga: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_gga_applied) |->
      (out_sentence_class == nsc_pkg::CLS_GGA && out_type_letters == nsc_pkg::TYPE_GGA))
    else $error("fix update from a sentence other than GGA");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .empty               (empty),
  .pop                 (pop),
  .out_event_kind      (out_event_kind),
  .out_sentence_class  (out_sentence_class),
  .out_type_letters    (out_type_letters),
  .out_gga_applied     (out_gga_applied),
  .out_valid_total     (out_valid_total)
);
